FILE: rtl/atps_pkg.sv
// Package for the autothrottle speed hold: widths, codes, FSM and op types,
// and the command/status structs shared by controller and datapath.
// No dependencies.
package atps_pkg;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 24;

    localparam int MACH_W  = 14;
    localparam int SPD_W   = 16;
    localparam int THR_W   = 16;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 24;
    localparam int ERR_W   = 17;
    localparam int INTEG_W = 28;
    localparam int ISUM_W  = 34;
    localparam int STEP_W  = 18;
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;

    localparam int DEF_SPEED_STEP = 64;
    localparam int DEF_GUARD_RATE = 6554;

    localparam logic signed [ISUM_W-1:0] INTEG_LIMIT = 34'sd125829120;
    localparam logic signed [15:0]       PRESS_LEVEL = 16'sd16384;

    localparam logic [1:0] OFF_NONE    = 2'd0;
    localparam logic [1:0] OFF_CMD     = 2'd1;
    localparam logic [1:0] OFF_MACH    = 2'd2;
    localparam logic [1:0] REF_NONE    = 2'd0;
    localparam logic [1:0] REF_MACH    = 2'd1;
    localparam logic [1:0] REF_GROUND  = 2'd2;

    typedef enum logic [2:0] {
        CFG_DISC_MACH  = 3'd0,
        CFG_MAX_MACH   = 3'd1,
        CFG_BASE_THR   = 3'd2,
        CFG_PROP_GAIN  = 3'd3,
        CFG_INTEG_GAIN = 3'd4,
        CFG_THR_CEIL   = 3'd5,
        CFG_MIN_TGT    = 3'd6,
        CFG_MAX_TGT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_TOGGLE   = 3'd0,
        CMD_ENGAGE   = 3'd1,
        CMD_DISENG   = 3'd2,
        CMD_SPEED_UP = 3'd3,
        CMD_SPEED_DN = 3'd4
    } t_cmd_id;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PI_MUL_ERR,
        ST_PI_INTEG,
        ST_PI_BASE,
        ST_PI_SUM,
        ST_PI_FIN,
        ST_RAMP_MUL,
        ST_RAMP_FIN,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ZERO_THR,
        OP_DROP_CMD,
        OP_DROP_MACH,
        OP_ENGAGE,
        OP_STEP_UP,
        OP_STEP_DN,
        OP_PI_ERR,
        OP_PI_MUL_ERR,
        OP_PI_INTEG,
        OP_PI_BASE,
        OP_PI_SUM,
        OP_PI_FIN,
        OP_RAMP_MUL,
        OP_RAMP_FIN
    } t_op;

    typedef struct packed {
        logic load_in;
        t_op  op;
        logic set_acc;
        logic acc_val;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic       is_tick;
        logic       pressed;
        logic [2:0] cmd_id;
        logic       engaged;
        logic       gt_disc;
        logic       gt_max;
    } t_status;

endpackage

FILE: rtl/atps_ctrl.sv
// Controller FSM: sequences decode, PI and ramp steps and the output beat.
// Depends on atps_pkg.
module atps_ctrl
    import atps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ctrl          = '0;
        o_ctrl.op       = OP_NONE;
        o_s_tready      = 1'b0;
        n_m_tvalid      = r_m_tvalid & ~i_m_tready;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state        = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_ctrl.set_acc = 1'b1;
                n_state        = ST_DONE;
                if (i_status.is_tick) begin
                    if (!i_status.engaged) begin
                        o_ctrl.op = OP_ZERO_THR;
                    end else if (i_status.gt_disc) begin
                        o_ctrl.op = OP_DROP_MACH;
                    end else if (i_status.gt_max) begin
                        n_state = ST_RAMP_MUL;
                    end else begin
                        o_ctrl.op = OP_PI_ERR;
                        n_state   = ST_PI_MUL_ERR;
                    end
                end else if (i_status.pressed) begin
                    o_ctrl.acc_val = 1'b1;
                    case (i_status.cmd_id)
                        CMD_TOGGLE: begin
                            o_ctrl.op = i_status.engaged ? OP_DROP_CMD : OP_ENGAGE;
                        end
                        CMD_ENGAGE: begin
                            o_ctrl.op = i_status.engaged ? OP_NONE : OP_ENGAGE;
                        end
                        CMD_DISENG: begin
                            o_ctrl.op = OP_DROP_CMD;
                        end
                        CMD_SPEED_UP: begin
                            o_ctrl.op = i_status.engaged ? OP_STEP_UP : OP_NONE;
                        end
                        CMD_SPEED_DN: begin
                            o_ctrl.op = i_status.engaged ? OP_STEP_DN : OP_NONE;
                        end
                        default: begin
                            o_ctrl.acc_val = 1'b0;
                        end
                    endcase
                end
            end
            ST_PI_MUL_ERR: begin
                o_ctrl.op = OP_PI_MUL_ERR;
                n_state   = ST_PI_INTEG;
            end
            ST_PI_INTEG: begin
                o_ctrl.op = OP_PI_INTEG;
                n_state   = ST_PI_BASE;
            end
            ST_PI_BASE: begin
                o_ctrl.op = OP_PI_BASE;
                n_state   = ST_PI_SUM;
            end
            ST_PI_SUM: begin
                o_ctrl.op = OP_PI_SUM;
                n_state   = ST_PI_FIN;
            end
            ST_PI_FIN: begin
                o_ctrl.op = OP_PI_FIN;
                n_state   = ST_DONE;
            end
            ST_RAMP_MUL: begin
                o_ctrl.op = OP_RAMP_MUL;
                n_state   = ST_RAMP_FIN;
            end
            ST_RAMP_FIN: begin
                o_ctrl.op = OP_RAMP_FIN;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    o_ctrl.load_out = 1'b1;
                    n_m_tvalid      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;

endmodule

FILE: rtl/atps_dp.sv
// Datapath: config registers, loop state, shared multiplier, accumulator
// and the output beat register. Depends on atps_pkg.
module atps_dp
    import atps_pkg::*;
#(
    parameter int SPEED_STEP = DEF_SPEED_STEP,
    parameter int GUARD_RATE = DEF_GUARD_RATE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  t_ctrl                 i_ctrl,
    output t_status               o_status,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    // latched beat
    logic                     r_kind;
    logic [2:0]               r_id;
    logic signed [15:0]       r_val;
    logic [MACH_W-1:0]        r_mach;
    logic [SPD_W-1:0]         r_spd;
    logic                     r_gnd;
    logic [DT_W-1:0]          r_dt;

    // config
    logic [MACH_W-1:0]        r_disc, r_maxm;
    logic [THR_W-1:0]         r_base, r_ceil;
    logic signed [GAIN_W-1:0] r_kp, r_ki;
    logic [SPD_W-1:0]         r_tmin, r_tmax;

    // loop state
    logic                     r_eng;
    logic [THR_W-1:0]         r_thr;
    logic [SPD_W-1:0]         r_tgt;
    logic signed [INTEG_W-1:0] r_integ;
    logic [1:0]               r_off, r_ref;
    logic                     r_cacc;

    // work
    logic signed [ERR_W-1:0]  r_err;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [OUT_DATA_W-1:0]    r_out;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [STEP_W-1:0]  w_step_sum, w_step_lo, w_step_hi;
    logic signed [ISUM_W-1:0]  w_isum;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [ISUM_W-1:0]  w_ramp;
    logic [THR_W-1:0]          w_pi_thr;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_kind <= i_s_tuser;
            r_id   <= i_s_tdata[2:0];
            r_val  <= i_s_tdata[18:3];
            r_mach <= i_s_tdata[32:19];
            r_spd  <= i_s_tdata[48:33];
            r_gnd  <= i_s_tdata[49];
            r_dt   <= i_s_tdata[65:50];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc <= MACH_W'(6144);
            r_maxm <= MACH_W'(5734);
            r_base <= THR_W'(32768);
            r_kp   <= GAIN_W'(3277);
            r_ki   <= GAIN_W'(655);
            r_ceil <= THR_W'(65535);
            r_tmin <= SPD_W'(3200);
            r_tmax <= SPD_W'(19200);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DISC_MACH:  r_disc <= i_cfg_wdata[MACH_W-1:0];
                CFG_MAX_MACH:   r_maxm <= i_cfg_wdata[MACH_W-1:0];
                CFG_BASE_THR:   r_base <= i_cfg_wdata[THR_W-1:0];
                CFG_PROP_GAIN:  r_kp   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_ki   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_THR_CEIL:   r_ceil <= i_cfg_wdata[THR_W-1:0];
                CFG_MIN_TGT:    r_tmin <= i_cfg_wdata[SPD_W-1:0];
                CFG_MAX_TGT:    r_tmax <= i_cfg_wdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_status.is_tick = r_kind;
    assign o_status.pressed = r_val > PRESS_LEVEL;
    assign o_status.cmd_id  = r_id;
    assign o_status.engaged = r_eng;
    assign o_status.gt_disc = r_mach > r_disc;
    assign o_status.gt_max  = r_mach > r_maxm;

    // shared multiplier operand select
    always_comb begin
        case (i_ctrl.op)
            OP_PI_MUL_ERR: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed(MUL_B_W'(r_dt));
            end
            OP_PI_INTEG: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_kp);
            end
            OP_PI_BASE: begin
                w_mul_a = MUL_A_W'(r_integ);
                w_mul_b = MUL_B_W'(r_ki);
            end
            OP_RAMP_MUL: begin
                w_mul_a = $signed(MUL_A_W'(r_dt));
                w_mul_b = MUL_B_W'(GUARD_RATE);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // target step with min then max clamp
    always_comb begin
        if (i_ctrl.op == OP_STEP_DN) begin
            w_step_sum = $signed({2'b00, r_tgt}) - STEP_W'(SPEED_STEP);
        end else begin
            w_step_sum = $signed({2'b00, r_tgt}) + STEP_W'(SPEED_STEP);
        end
        w_step_lo = (w_step_sum < $signed({2'b00, r_tmin})) ?
                    $signed({2'b00, r_tmin}) : w_step_sum;
        w_step_hi = (w_step_lo > $signed({2'b00, r_tmax})) ?
                    $signed({2'b00, r_tmax}) : w_step_lo;
    end

    // integral update and clamp
    always_comb begin
        w_isum = ISUM_W'(r_integ) + ISUM_W'(r_prod);
        if (w_isum > INTEG_LIMIT) begin
            w_integ = INTEG_W'(INTEG_LIMIT);
        end else if (w_isum < -INTEG_LIMIT) begin
            w_integ = INTEG_W'(-INTEG_LIMIT);
        end else begin
            w_integ = w_isum[INTEG_W-1:0];
        end
    end

    assign w_ramp = $signed({2'b00, r_thr, 16'h0000}) - $signed({1'b0, r_prod[32:0]});

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            w_pi_thr = '0;
        end else if (r_acc[ACC_W-1:22] > (ACC_W-22)'(r_ceil)) begin
            w_pi_thr = r_ceil;
        end else begin
            w_pi_thr = r_acc[37:22];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng   <= 1'b0;
            r_thr   <= '0;
            r_tgt   <= '0;
            r_integ <= '0;
            r_off   <= OFF_NONE;
            r_ref   <= REF_NONE;
            r_cacc  <= 1'b0;
        end else begin
            if (i_ctrl.set_acc) begin
                r_cacc <= i_ctrl.acc_val;
            end
            case (i_ctrl.op)
                OP_ZERO_THR: begin
                    r_thr <= '0;
                end
                OP_DROP_CMD, OP_DROP_MACH: begin
                    r_off   <= (i_ctrl.op == OP_DROP_CMD) ? OFF_CMD : OFF_MACH;
                    r_eng   <= 1'b0;
                    r_thr   <= '0;
                    r_integ <= '0;
                end
                OP_ENGAGE: begin
                    if (o_status.gt_max) begin
                        r_ref <= REF_MACH;
                    end else if (r_gnd) begin
                        r_ref <= REF_GROUND;
                    end else begin
                        r_ref   <= REF_NONE;
                        r_eng   <= 1'b1;
                        r_off   <= OFF_NONE;
                        r_tgt   <= r_spd;
                        r_integ <= '0;
                    end
                end
                OP_STEP_UP, OP_STEP_DN: begin
                    r_tgt <= w_step_hi[SPD_W-1:0];
                end
                OP_PI_INTEG: begin
                    r_integ <= w_integ;
                end
                OP_PI_FIN: begin
                    r_thr <= w_pi_thr;
                end
                OP_RAMP_FIN: begin
                    r_thr <= w_ramp[ISUM_W-1] ? '0 : w_ramp[31:16];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_PI_ERR: begin
                r_err <= $signed({1'b0, r_tgt}) - $signed({1'b0, r_spd});
            end
            OP_PI_MUL_ERR, OP_PI_INTEG, OP_RAMP_MUL: begin
                r_prod <= w_prod;
            end
            OP_PI_BASE: begin
                r_acc  <= $signed({{(ACC_W-38){1'b0}}, r_base, 22'h000000})
                        + (ACC_W'(r_prod) <<< 16);
                r_prod <= w_prod;
            end
            OP_PI_SUM: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_out <= {2'b00, r_ref, r_off, r_tgt, r_thr, r_eng, r_cacc};
        end
    end

    assign o_m_tdata = r_out;

endmodule

FILE: rtl/autothrottle_pi_speed_hold.sv
// Autothrottle speed hold top level: PI speed loop with integral clamp.
// Depends on atps_pkg, atps_ctrl, atps_dp.
//
//  channel  dir  handshake              payload
//  s        in   i_s_tvalid/o_s_tready  i_s_tdata[65:0], i_s_tuser[0]
//  m        out  o_m_tvalid/i_m_tready  o_m_tdata[37:0]
//  cfg      in   i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// Commands and loop-off ticks go from accept through decide to the output beat;
// Mach ramp ticks add a multiply and a finish step, and PI ticks run the shared
// 28x25 multiplier for the three PI products one per cycle, then sum and clamp.
// A new beat is taken once the current one has moved to the output register,
// so one result may wait on m while the next beat is accepted.
// Synchronous active-low reset restores register defaults; no clearing pass.
module autothrottle_pi_speed_hold
    import atps_pkg::*;
#(
    parameter int SPEED_STEP = DEF_SPEED_STEP,
    parameter int GUARD_RATE = DEF_GUARD_RATE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // command_id, command_value, mach_number, airspeed, on_ground,
    // tick_seconds, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [0:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // cmd_accepted, is_engaged, throttle_out, target_speed, off_reason,
    // refuse_reason, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    t_ctrl   w_ctrl;
    t_status w_status;

    atps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    atps_dp #(
        .SPEED_STEP (SPEED_STEP),
        .GUARD_RATE (GUARD_RATE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser[0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

FILE: dv/autothrottle_pi_speed_hold_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for autothrottle_pi_speed_hold: a directed table, then random
// command and tick beats across several register settings, all checked in order.
// Depends on atps_pkg and the RTL top; holds its own speed-hold predictor.
module autothrottle_pi_speed_hold_tb;
    import atps_pkg::*;

    localparam logic       REQ_CMD        = 1'b0;
    localparam logic       REQ_TICK       = 1'b1;
    localparam logic [2:0] CMD_RSVD5      = 3'd5;
    localparam logic [2:0] CMD_RSVD6      = 3'd6;
    localparam logic [2:0] CMD_RSVD7      = 3'd7;
    localparam int         N_PHASE        = 10;
    localparam int         PHASE_ITEMS    = 150;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 12;
    localparam longint     INTEG_LIM      = longint'(INTEG_LIMIT);

    typedef struct packed {
        logic        tick;
        logic [2:0]  id;
        logic [15:0] cval;
        logic [13:0] mach;
        logic [15:0] spd;
        logic        gnd;
        logic [15:0] dt;
    } t_hold_item;

    typedef struct packed {
        logic        accepted;
        logic        engaged;
        logic [15:0] throttle;
        logic [15:0] target;
        logic [1:0]  off_rsn;
        logic [1:0]  refuse_rsn;
    } t_status_beat;

    typedef struct packed {
        t_hold_item   it;
        logic         typed;
        t_status_beat want;
    } t_hold_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [0:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    autothrottle_pi_speed_hold u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of registers and loop state
    int     cfg_disc  = 6144;
    int     cfg_maxm  = 5734;
    int     cfg_base  = 32768;
    int     cfg_prop  = 3277;
    int     cfg_integ = 655;
    int     cfg_ceil  = 65535;
    int     cfg_min   = 3200;
    int     cfg_max   = 19200;
    bit     hold_engaged  = 1'b0;
    int     hold_throttle = 0;
    int     hold_target   = 0;
    int     hold_off      = 0;
    int     hold_refuse   = 0;
    longint hold_integral = 0;

    t_status_beat pending_status[$];
    t_hold_row    directed_rows[$];
    bit           idle_on = 1'b1;
    int           rx_hold = 0;
    int           quiet_cycles = 0;
    int           n_items = 0;
    int           n_checked = 0;
    int           n_mismatch = 0;
    int           n_pi = 0;
    int           n_ramp = 0;
    int           n_trip = 0;
    int           n_refused = 0;

    function automatic void hold_drop(int reason);
        if (hold_engaged || reason == int'(OFF_CMD)) hold_off = reason;
        hold_engaged  = 1'b0;
        hold_throttle = 0;
        hold_integral = 0;
    endfunction

    function automatic void hold_engage(t_hold_item it);
        hold_refuse = int'(REF_NONE);
        if (int'(it.mach) > cfg_maxm) hold_refuse = int'(REF_MACH);
        else if (it.gnd) hold_refuse = int'(REF_GROUND);
        if (hold_refuse != int'(REF_NONE)) begin
            n_refused++;
            return;
        end
        hold_engaged  = 1'b1;
        hold_off      = int'(OFF_NONE);
        hold_target   = int'(it.spd);
        hold_integral = 0;
    endfunction

    function automatic void hold_step_target(int dir);
        int v;
        v = hold_target + dir * DEF_SPEED_STEP;
        if (v < cfg_min) v = cfg_min;
        if (v > cfg_max) v = cfg_max;
        hold_target = v & 'hFFFF;
    endfunction

    function automatic t_status_beat predict_hold_status(t_hold_item it);
        t_status_beat b;
        logic         accepted;
        longint       err;
        longint       integ;
        longint       cmd;
        longint       ramp;
        accepted = 1'b0;
        if (it.tick == REQ_TICK) begin
            if (!hold_engaged) begin
                hold_throttle = 0;
            end else if (int'(it.mach) > cfg_disc) begin
                hold_drop(int'(OFF_MACH));
                n_trip++;
            end else if (int'(it.mach) > cfg_maxm) begin
                ramp = longint'(hold_throttle) * 65536
                     - longint'(DEF_GUARD_RATE) * longint'(it.dt);
                if (ramp < 0) ramp = 0;
                hold_throttle = int'(ramp >>> 16);
                n_ramp++;
            end else begin
                err   = longint'(hold_target) - longint'(it.spd);
                integ = hold_integral + err * longint'(it.dt);
                if (integ > INTEG_LIM) integ = INTEG_LIM;
                if (integ < -INTEG_LIM) integ = -INTEG_LIM;
                hold_integral = integ;
                cmd = longint'(cfg_base) * 4194304
                    + longint'(cfg_prop) * err * 65536
                    + longint'(cfg_integ) * integ;
                if (cmd < 0) cmd = 0;
                cmd = cmd >>> 22;
                if (cmd > longint'(cfg_ceil)) cmd = longint'(cfg_ceil);
                hold_throttle = int'(cmd);
                n_pi++;
            end
        end else if ($signed(it.cval) > PRESS_LEVEL) begin
            accepted = 1'b1;
            case (it.id)
                CMD_TOGGLE: begin
                    if (hold_engaged) hold_drop(int'(OFF_CMD));
                    else hold_engage(it);
                end
                CMD_ENGAGE: begin
                    if (!hold_engaged) hold_engage(it);
                end
                CMD_DISENG: hold_drop(int'(OFF_CMD));
                CMD_SPEED_UP: begin
                    if (hold_engaged) hold_step_target(1);
                end
                CMD_SPEED_DN: begin
                    if (hold_engaged) hold_step_target(-1);
                end
                default: accepted = 1'b0;
            endcase
        end
        b.accepted   = accepted;
        b.engaged    = hold_engaged;
        b.throttle   = hold_throttle[15:0];
        b.target     = hold_target[15:0];
        b.off_rsn    = hold_off[1:0];
        b.refuse_rsn = hold_refuse[1:0];
        return b;
    endfunction

    function automatic t_hold_item mk_item(logic tick, logic [2:0] id, logic [15:0] cval,
                                           logic [13:0] mach, logic [15:0] spd, logic gnd,
                                           logic [15:0] dt);
        t_hold_item it;
        it.tick = tick;
        it.id   = id;
        it.cval = cval;
        it.mach = mach;
        it.spd  = spd;
        it.gnd  = gnd;
        it.dt   = dt;
        return it;
    endfunction

    function automatic t_status_beat mk_beat(logic acc, logic eng, logic [15:0] thr,
                                             logic [15:0] tgt, logic [1:0] off_rsn,
                                             logic [1:0] refuse_rsn);
        t_status_beat b;
        b.accepted   = acc;
        b.engaged    = eng;
        b.throttle   = thr;
        b.target     = tgt;
        b.off_rsn    = off_rsn;
        b.refuse_rsn = refuse_rsn;
        return b;
    endfunction

    function automatic void add_row(t_hold_item it, logic typed, t_status_beat want);
        t_hold_row row;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // mostly well-formed: engage when off, ticks near the target, speed steps;
    // the rest is full-range noise
    function automatic t_hold_item random_hold_item();
        t_hold_item it;
        int         r;
        int         zone;
        int         s;
        int         pi_top;
        r       = $urandom_range(0, 99);
        it.tick = 1'($urandom);
        it.id   = 3'($urandom);
        it.cval = 16'($urandom);
        it.mach = 14'($urandom);
        it.spd  = 16'($urandom);
        it.gnd  = 1'($urandom);
        it.dt   = 16'($urandom);
        if (r < 12) return it;
        if (!hold_engaged && r < 45) begin
            it.tick = REQ_CMD;
            it.id   = $urandom_range(0, 1) ? CMD_ENGAGE : CMD_TOGGLE;
            it.cval = 16'($urandom_range(16385, 32767));
            it.mach = 14'(($urandom_range(0, 9) == 0) ? $urandom
                                                       : $urandom_range(0, cfg_maxm));
            it.spd  = 16'($urandom_range(1000, 30000));
            it.gnd  = ($urandom_range(0, 9) == 0);
        end else if (r < 75) begin
            it.tick = REQ_TICK;
            pi_top  = (cfg_maxm < cfg_disc) ? cfg_maxm : cfg_disc;
            zone    = $urandom_range(0, 9);
            if (zone == 0 && cfg_disc < 16383)
                it.mach = 14'($urandom_range(cfg_disc + 1, 16383));
            else if (zone <= 2 && cfg_maxm < cfg_disc)
                it.mach = 14'($urandom_range(cfg_maxm + 1, cfg_disc));
            else it.mach = 14'($urandom_range(0, pi_top));
            s = hold_target + int'($urandom_range(0, 2048)) - 1024;
            if (s < 0) s = 0;
            if (s > 65535) s = 65535;
            it.spd = 16'(s);
            if ($urandom_range(0, 9) != 0) it.dt = 16'($urandom_range(0, 6554));
        end else begin
            it.tick = REQ_CMD;
            zone    = $urandom_range(0, 9);
            if (zone < 3) it.id = CMD_SPEED_UP;
            else if (zone < 6) it.id = CMD_SPEED_DN;
            if ($urandom_range(0, 99) < 85) it.cval = 16'($urandom_range(16385, 32767));
        end
        return it;
    endfunction

    task automatic send_item(t_hold_item it, logic typed, t_status_beat want);
        t_status_beat b;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = it.tick;
        i_s_tdata  = {6'd0, it.dt, it.gnd, it.spd, it.mach, it.cval, it.id};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        b = predict_hold_status(it);
        if (typed) b = want;
        pending_status.push_back(b);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [23:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = v;
        case (idx)
            CFG_DISC_MACH:  cfg_disc  = int'(v[13:0]);
            CFG_MAX_MACH:   cfg_maxm  = int'(v[13:0]);
            CFG_BASE_THR:   cfg_base  = int'(v[15:0]);
            CFG_PROP_GAIN:  cfg_prop  = {{8{v[23]}}, v};
            CFG_INTEG_GAIN: cfg_integ = {{8{v[23]}}, v};
            CFG_THR_CEIL:   cfg_ceil  = int'(v[15:0]);
            CFG_MIN_TGT:    cfg_min   = int'(v[15:0]);
            CFG_MAX_TGT:    cfg_max   = int'(v[15:0]);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_phase(int phase);
        logic [23:0] d, m, b, p, g, c, lo, hi;
        d  = 24'($urandom_range(4096, 8192));
        m  = 24'($urandom_range(3500, d));
        b  = 24'($urandom_range(0, 65535));
        p  = 24'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32768) - 16384);
        g  = 24'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 4096) - 2048);
        c  = 24'($urandom_range(16384, 65535));
        lo = 24'($urandom_range(0, 8000));
        hi = 24'(($urandom_range(0, 9) == 0) ? $urandom_range(0, lo)
                                              : $urandom_range(lo, 40000));
        case (phase)
            1: begin
                d = 24'd16383; m = 24'd16383; b = 24'd65535; p = 24'h7FFFFF; g = 24'h7FFFFF;
                c = 24'd65535; lo = 24'd0; hi = 24'd65535;
            end
            2: begin
                // inverted target limits, all else at the bottom
                d = 24'd0; m = 24'd0; b = 24'd0; p = 24'h800000; g = 24'h800000;
                c = 24'd0; lo = 24'd65535; hi = 24'd0;
            end
            3: begin
                // disconnect below the engage limit
                d = 24'd4000; m = 24'd6000;
            end
            default: ;
        endcase
        write_reg(CFG_DISC_MACH, d);
        write_reg(CFG_MAX_MACH, m);
        write_reg(CFG_BASE_THR, b);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, g);
        write_reg(CFG_THR_CEIL, c);
        write_reg(CFG_MIN_TGT, lo);
        write_reg(CFG_MAX_TGT, hi);
        i_cfg_we = 1'b0;
    endtask

    // output side stalls in random bursts while idle_on is set
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_hold    <= $urandom_range(0, 14);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_status_beat got;
        t_status_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.accepted   = o_m_tdata[0];
            got.engaged    = o_m_tdata[1];
            got.throttle   = o_m_tdata[17:2];
            got.target     = o_m_tdata[33:18];
            got.off_rsn    = o_m_tdata[35:34];
            got.refuse_rsn = o_m_tdata[37:36];
            n_checked++;
            if (pending_status.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] unexpected status beat: %h", $realtime, o_m_tdata);
            end else begin
                want = pending_status.pop_front();
                if (got.accepted !== want.accepted || got.engaged !== want.engaged ||
                    got.throttle !== want.throttle || got.target !== want.target ||
                    got.off_rsn !== want.off_rsn || got.refuse_rsn !== want.refuse_rsn) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("[%0t] status mismatch, beat %0d", $realtime, n_checked);
                        $display("  exp acc=%0d eng=%0d thr=%0d tgt=%0d off=%0d refuse=%0d",
                                 want.accepted, want.engaged, want.throttle, want.target,
                                 want.off_rsn, want.refuse_rsn);
                        $display("  got acc=%0d eng=%0d thr=%0d tgt=%0d off=%0d refuse=%0d",
                                 got.accepted, got.engaged, got.throttle, got.target,
                                 got.off_rsn, got.refuse_rsn);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_status.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_status_beat none;
        none        = '0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // register defaults: disc 6144, engage limit 5734, base 0.5, limits 3200..19200
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd16383, 16'd0, 1'b0, 16'd65535),
                1'b1, mk_beat(1'b0, 1'b0, 16'd0, 16'd0, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_TOGGLE, 16'd16384, 14'd0, 16'd6400, 1'b0, 16'd0),
                1'b1, mk_beat(1'b0, 1'b0, 16'd0, 16'd0, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_RSVD7, 16'h7FFF, 14'd0, 16'd6400, 1'b0, 16'd0),
                1'b1, mk_beat(1'b0, 1'b0, 16'd0, 16'd0, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_ENGAGE, 16'h7FFF, 14'd5735, 16'd6400, 1'b1, 16'd0),
                1'b1, mk_beat(1'b1, 1'b0, 16'd0, 16'd0, OFF_NONE, REF_MACH));
        add_row(mk_item(REQ_CMD, CMD_TOGGLE, 16'd16385, 14'd5734, 16'd6400, 1'b1, 16'd0),
                1'b1, mk_beat(1'b1, 1'b0, 16'd0, 16'd0, OFF_NONE, REF_GROUND));
        add_row(mk_item(REQ_CMD, CMD_TOGGLE, 16'h7FFF, 14'd5734, 16'd6400, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd6400, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_ENGAGE, 16'h7FFF, 14'd16383, 16'd100, 1'b1, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd6400, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_SPEED_UP, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd6464, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_SPEED_DN, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd6400, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd5734, 16'd6400, 1'b0, 16'd65535),
                1'b1, mk_beat(1'b0, 1'b1, 16'd32768, 16'd6400, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd0, 16'd0, 1'b0, 16'd65535),
                1'b0, none);
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd0, 16'd65535, 1'b0, 16'd65535),
                1'b0, none);
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd6144, 16'd0, 1'b0, 16'd65535),
                1'b0, none);
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd6145, 16'd0, 1'b0, 16'd100),
                1'b1, mk_beat(1'b0, 1'b0, 16'd0, 16'd6400, OFF_MACH, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_DISENG, 16'd16385, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b0, 16'd0, 16'd6400, OFF_CMD, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_SPEED_UP, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b0, 16'd0, 16'd6400, OFF_CMD, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_ENGAGE, 16'h7FFF, 14'd0, 16'd65535, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd65535, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_SPEED_UP, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd19200, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_SPEED_DN, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b1, 16'd0, 16'd19136, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_CMD, CMD_TOGGLE, 16'h8000, 14'd16383, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b0, 1'b1, 16'd0, 16'd19136, OFF_NONE, REF_NONE));
        add_row(mk_item(REQ_TICK, CMD_RSVD5, 16'hFFFF, 14'd0, 16'd19136, 1'b1, 16'd0),
                1'b0, none);
        add_row(mk_item(REQ_CMD, CMD_RSVD6, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b0, none);
        add_row(mk_item(REQ_CMD, CMD_TOGGLE, 16'h7FFF, 14'd0, 16'd0, 1'b0, 16'd0),
                1'b1, mk_beat(1'b1, 1'b0, 16'd0, 16'd19136, OFF_CMD, REF_NONE));
        add_row(mk_item(REQ_TICK, CMD_TOGGLE, 16'd0, 14'd16383, 16'd65535, 1'b1, 16'd65535),
                1'b0, none);

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < N_PHASE; phase++) begin
            if (phase > 0) begin
                wait_idle();
                program_phase(phase);
            end
            idle_on = (phase != 5 && phase != N_PHASE - 1);
            repeat (PHASE_ITEMS) send_item(random_hold_item(), 1'b0, none);
        end
        wait_idle();

        $display("Ran %0d beats over %0d register settings: %0d PI ticks, %0d ramp ticks,",
                 n_items, N_PHASE, n_pi, n_ramp);
        $display("%0d Mach trips, %0d refused engages; %0d results checked, %0d mismatches",
                 n_trip, n_refused, n_checked, n_mismatch);
        if (n_mismatch == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/atps_pkg.sv
rtl/atps_ctrl.sv
rtl/atps_dp.sv
rtl/autothrottle_pi_speed_hold.sv
dv/autothrottle_pi_speed_hold_tb.sv
